FILE: src/assert_macros.svh
// Assertion macros shared by the display converter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising edge outside of reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// A condition that must be followed by an expected one in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, expect_next, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_next)) \
    else $error(msg);

`endif

FILE: src/erss_pkg.sv
package erss_pkg;

  localparam int ECHO_WIDTH_DEF = 16;

  // Range limits in microseconds of echo time.
  localparam int LIMIT_FINE = 580;
  localparam int LIMIT_MID  = 5800;
  // Above this echo time the coarse range shows more than 9999.
  localparam int LIMIT_OVF  = 58000;

  localparam logic [9:0] SCALE_FINE   = 10'd1000;
  localparam logic [9:0] SCALE_MID    = 10'd100;
  localparam logic [9:0] SCALE_COARSE = 10'd10;

  localparam logic [2:0] POINT_FINE   = 3'd4;
  localparam logic [2:0] POINT_MID    = 3'd3;
  localparam logic [2:0] POINT_COARSE = 3'd2;

  // Scaled echo is kept below 58 * 10000, so 20 bits hold it.
  localparam int PROD_W = 20;
  localparam int ECHO_CLIP_W = 16;

  // floor(p / 58) as (p * ceil(2^26 / 58)) >> 26, exact for p < 2^20.
  localparam int          DIV58_SHIFT = 26;
  localparam int          DIV58_MUL_W = 21;
  localparam logic [20:0] DIV58_MUL   = 21'd1157050;

  localparam int          VALUE_W    = 14;
  localparam logic [13:0] MAX_SHOWN  = 14'd9999;

  // floor(v / 100) for v < 10000.
  localparam int          DIV100_SHIFT = 20;
  localparam logic [13:0] DIV100_MUL   = 14'd10486;
  localparam logic [13:0] HUNDRED      = 14'd100;

  // floor(x / 10) for x < 100.
  localparam int          DIV10_SHIFT = 10;
  localparam logic [6:0]  DIV10_MUL   = 7'd103;
  localparam logic [6:0]  TEN         = 7'd10;

  localparam logic [3:0]  DIGIT_MAX   = 4'd9;
  localparam int          DIGITS      = 4;
  localparam int          PAIR_W      = 7;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [2:0]         point;
    logic               ovf;
  } scaled_t;

  typedef struct packed {
    logic [DIGITS-1:0][3:0] digit;
    logic [2:0]             point;
    logic                   ovf;
  } digits_t;

  typedef struct packed {
    logic [DIGITS-1:0][3:0] digit;
    logic [DIGITS-1:0][7:0] seg;
    logic [2:0]             point;
    logic                   ovf;
  } disp_t;

  // Segments a..g in bits 0..6.
  function automatic logic [6:0] seg_of_digit(input logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

FILE: src/erss_scale.sv
`include "assert_macros.svh"

module erss_scale #(
  parameter int ECHO_WIDTH = erss_pkg::ECHO_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ECHO_WIDTH-1:0] in_echo,
  output logic                  out_valid,
  input  logic                  out_ready,
  output erss_pkg::scaled_t     out_data
);

  localparam int W_CMP = (ECHO_WIDTH > erss_pkg::ECHO_CLIP_W) ?
                         ECHO_WIDTH : erss_pkg::ECHO_CLIP_W;
  localparam int MUL58_W = erss_pkg::PROD_W + erss_pkg::DIV58_MUL_W;

  logic [W_CMP-1:0]                 echo_x;
  logic [9:0]                       scale;
  logic [2:0]                       point_nxt;
  logic                             ovf_nxt;
  logic [erss_pkg::ECHO_CLIP_W-1:0] echo_clip;
  logic [erss_pkg::PROD_W-1:0]      p_nxt;

  logic                        s1_v_r;
  logic [erss_pkg::PROD_W-1:0] s1_p_r;
  logic [2:0]                  s1_point_r;
  logic                        s1_ovf_r;
  logic                        s1_rdy;

  logic [MUL58_W-1:0]             prod58;
  erss_pkg::scaled_t              s2_nxt;
  logic                           s2_v_r;
  erss_pkg::scaled_t              s2_r;
  logic                           s2_rdy;

  assign s2_rdy   = !s2_v_r || out_ready;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  // Stage one: range select and scaling by a power of ten.
  always_comb begin
    echo_x  = W_CMP'(in_echo);
    ovf_nxt = (echo_x >= W_CMP'(erss_pkg::LIMIT_OVF));
    if (echo_x < W_CMP'(erss_pkg::LIMIT_FINE)) begin
      scale     = erss_pkg::SCALE_FINE;
      point_nxt = erss_pkg::POINT_FINE;
    end else if (echo_x < W_CMP'(erss_pkg::LIMIT_MID)) begin
      scale     = erss_pkg::SCALE_MID;
      point_nxt = erss_pkg::POINT_MID;
    end else begin
      scale     = erss_pkg::SCALE_COARSE;
      point_nxt = erss_pkg::POINT_COARSE;
    end
    // Saturated items need no product; zero keeps the multiplier in range.
    echo_clip = ovf_nxt ? '0 : echo_x[erss_pkg::ECHO_CLIP_W-1:0];
    p_nxt     = erss_pkg::PROD_W'(echo_clip) * erss_pkg::PROD_W'(scale);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_p_r     <= p_nxt;
      s1_point_r <= point_nxt;
      s1_ovf_r   <= ovf_nxt;
    end
  end

  // Stage two: divide by 58 through a reciprocal multiply, then saturate.
  always_comb begin
    prod58       = MUL58_W'(s1_p_r) * MUL58_W'(erss_pkg::DIV58_MUL);
    s2_nxt.value = s1_ovf_r ? erss_pkg::MAX_SHOWN :
                   prod58[erss_pkg::DIV58_SHIFT +: erss_pkg::VALUE_W];
    s2_nxt.point = s1_point_r;
    s2_nxt.ovf   = s1_ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = s2_v_r;
  assign out_data  = s2_r;

  `ASSERT_AT(a_value_in_range, clk, rst_n, s2_v_r |-> (s2_r.value <= erss_pkg::MAX_SHOWN), "scaled value above 9999")
  `ASSERT_AT(a_ovf_coarse, clk, rst_n, (s2_v_r && s2_r.ovf) |-> ((s2_r.point == erss_pkg::POINT_COARSE) && (s2_r.value == erss_pkg::MAX_SHOWN)), "overflow outside the coarse range or not saturated")

endmodule

FILE: src/erss_digits.sv
`include "assert_macros.svh"

module erss_digits (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  erss_pkg::scaled_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output erss_pkg::digits_t out_data
);

  localparam int MUL100_W = 2 * erss_pkg::VALUE_W;
  localparam int MUL10_W  = 2 * erss_pkg::PAIR_W;

  // Stage three: hundreds part.
  logic [MUL100_W-1:0]         prod100;
  logic [erss_pkg::PAIR_W-1:0] q_nxt;
  logic                        s3_v_r;
  logic                        s3_rdy;
  logic [erss_pkg::PAIR_W-1:0] s3_q_r;
  erss_pkg::scaled_t           s3_r;

  // Stage four: remainder below one hundred.
  logic [erss_pkg::VALUE_W-1:0] rem_full;
  logic                         s4_v_r;
  logic                         s4_rdy;
  logic [erss_pkg::PAIR_W-1:0]  s4_hi_r;
  logic [erss_pkg::PAIR_W-1:0]  s4_lo_r;
  logic [2:0]                   s4_point_r;
  logic                         s4_ovf_r;

  // Stage five: tens and units of each half.
  logic [MUL10_W-1:0]           prod_hi;
  logic [MUL10_W-1:0]           prod_lo;
  logic [3:0]                   hi_tens;
  logic [3:0]                   lo_tens;
  logic [erss_pkg::PAIR_W-1:0]  hi_units;
  logic [erss_pkg::PAIR_W-1:0]  lo_units;
  erss_pkg::digits_t            s5_nxt;
  logic                         s5_v_r;
  logic                         s5_rdy;
  erss_pkg::digits_t            s5_r;

  assign s5_rdy   = !s5_v_r || out_ready;
  assign s4_rdy   = !s4_v_r || s5_rdy;
  assign s3_rdy   = !s3_v_r || s4_rdy;
  assign in_ready = s3_rdy;

  always_comb begin
    prod100 = MUL100_W'(in_data.value) * MUL100_W'(erss_pkg::DIV100_MUL);
    q_nxt   = prod100[erss_pkg::DIV100_SHIFT +: erss_pkg::PAIR_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      s3_q_r <= q_nxt;
      s3_r   <= in_data;
    end
  end

  always_comb begin
    rem_full = s3_r.value -
               erss_pkg::VALUE_W'(s3_q_r) * erss_pkg::HUNDRED;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s4_rdy) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_rdy) begin
      s4_hi_r    <= s3_q_r;
      s4_lo_r    <= rem_full[erss_pkg::PAIR_W-1:0];
      s4_point_r <= s3_r.point;
      s4_ovf_r   <= s3_r.ovf;
    end
  end

  always_comb begin
    prod_hi  = MUL10_W'(s4_hi_r) * MUL10_W'(erss_pkg::DIV10_MUL);
    prod_lo  = MUL10_W'(s4_lo_r) * MUL10_W'(erss_pkg::DIV10_MUL);
    hi_tens  = prod_hi[erss_pkg::DIV10_SHIFT +: 4];
    lo_tens  = prod_lo[erss_pkg::DIV10_SHIFT +: 4];
    hi_units = s4_hi_r - erss_pkg::PAIR_W'(hi_tens) * erss_pkg::TEN;
    lo_units = s4_lo_r - erss_pkg::PAIR_W'(lo_tens) * erss_pkg::TEN;
    s5_nxt.digit[3] = hi_tens;
    s5_nxt.digit[2] = hi_units[3:0];
    s5_nxt.digit[1] = lo_tens;
    s5_nxt.digit[0] = lo_units[3:0];
    s5_nxt.point    = s4_point_r;
    s5_nxt.ovf      = s4_ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (s5_rdy) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_rdy) begin
      s5_r <= s5_nxt;
    end
  end

  assign out_valid = s5_v_r;
  assign out_data  = s5_r;

  `ASSERT_NEXT(a_s3_advance, clk, rst_n, s3_v_r && s4_rdy, s4_v_r, "item lost between hundreds and remainder stages")

endmodule

FILE: src/erss_segs.sv
`include "assert_macros.svh"

module erss_segs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  erss_pkg::digits_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output erss_pkg::disp_t   out_data
);

  erss_pkg::disp_t disp_nxt;
  erss_pkg::disp_t disp_r;
  logic            v_r;
  logic            rdy;

  assign rdy      = !v_r || out_ready;
  assign in_ready = rdy;

  always_comb begin
    disp_nxt.digit = in_data.digit;
    disp_nxt.point = in_data.point;
    disp_nxt.ovf   = in_data.ovf;
    for (int i = 0; i < erss_pkg::DIGITS; i++) begin
      disp_nxt.seg[i] = {(in_data.point == 3'(i + 1)),
                         erss_pkg::seg_of_digit(in_data.digit[i])};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      disp_r <= disp_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = disp_r;

  `ASSERT_AT(a_one_point, clk, rst_n, v_r |-> ($onehot({disp_r.seg[3][7], disp_r.seg[2][7], disp_r.seg[1][7], disp_r.seg[0][7]})), "decimal point not lit on exactly one digit")
  `ASSERT_AT(a_digits_decimal, clk, rst_n, v_r |-> ((disp_r.digit[0] <= erss_pkg::DIGIT_MAX) && (disp_r.digit[1] <= erss_pkg::DIGIT_MAX) && (disp_r.digit[2] <= erss_pkg::DIGIT_MAX) && (disp_r.digit[3] <= erss_pkg::DIGIT_MAX)), "digit above nine")
  `ASSERT_AT(a_ovf_nines, clk, rst_n, (v_r && disp_r.ovf) |-> ((disp_r.digit[0] == erss_pkg::DIGIT_MAX) && (disp_r.digit[3] == erss_pkg::DIGIT_MAX)), "saturated item does not show 9999")

endmodule

FILE: src/echo_range_to_seven_segment_top.sv
// Throughput: one item per clock cycle while out_tready is high; each of the six register
// stages takes a new item whenever it is empty or its successor moves, so a stalled output
// loses nothing. The stage count is set by the divide-by-58 multiply and the three decimal
// split stages. Reset: synchronous, active low on rst_n; it clears all stage valid bits, so
// no result item is presented after reset until a new input item has been accepted.
module echo_range_to_seven_segment_top #(
  parameter int ECHO_WIDTH = erss_pkg::ECHO_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata from bit 0 up: echo_us (ECHO_WIDTH bits), zero fill to whole bytes.
  input  logic [((ECHO_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata from bit 0 up: digit_1, digit_2, digit_3, digit_4 (4 bits each),
  // seg_1, seg_2, seg_3, seg_4 (8 bits each), point_position (3 bits), 5 zero bits.
  output logic [55:0]                         out_tdata,
  // out_tuser: overflow, set when the shown value was saturated at 9999.
  output logic                                out_tuser
);

  // Stage interconnect between the scaling, decimal split and segment parts.
  logic              sc_valid;
  logic              sc_ready;
  erss_pkg::scaled_t sc_data;
  logic              dg_valid;
  logic              dg_ready;
  erss_pkg::digits_t dg_data;
  erss_pkg::disp_t   disp;

  // Stages one and two pick the range (580 us and 5800 us limits), multiply by
  // the range scale and divide by 58 with a reciprocal multiply. Echo times of
  // 58000 us and more saturate the shown value at 9999.
  erss_scale #(
    .ECHO_WIDTH (ECHO_WIDTH)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_echo   (in_tdata[ECHO_WIDTH-1:0]),
    .out_valid (sc_valid),
    .out_ready (sc_ready),
    .out_data  (sc_data)
  );

  // Stages three to five take the value apart into four decimal digits.
  erss_digits u_digits (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sc_valid),
    .in_ready  (sc_ready),
    .in_data   (sc_data),
    .out_valid (dg_valid),
    .out_ready (dg_ready),
    .out_data  (dg_data)
  );

  // Stage six encodes the segments, merges the decimal point and is the
  // output register of the block.
  erss_segs u_segs (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dg_valid),
    .in_ready  (dg_ready),
    .in_data   (dg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (disp)
  );

  assign out_tdata = {5'b0, disp.point,
                      disp.seg[3], disp.seg[2], disp.seg[1], disp.seg[0],
                      disp.digit[3], disp.digit[2], disp.digit[1], disp.digit[0]};
  assign out_tuser = disp.ovf;

endmodule
